@@ rtl/core/ljpf_pkg.sv @@
// shared types, constants and saturating helpers for the lennard-jones pair force block
// no dependencies
package ljpf_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned ADDR_W = 5;

	localparam logic [1:0] REG_WELL   = 2'd0;
	localparam logic [1:0] REG_SIGMA  = 2'd1;
	localparam logic [1:0] REG_CUTOFF = 2'd2;
	localparam logic [1:0] REG_VOLUME = 2'd3;

	localparam logic [63:0] SMAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] UMAX = 64'hffff_ffff_ffff_ffff;

	localparam logic RES_ATOM  = 1'b0;
	localparam logic RES_FRAME = 1'b1;

	typedef struct packed {
		logic        pair_valid;
		logic [2:0]  dn;
		logic [2:0][31:0] d;
		logic        atom_end;
		logic        frame_end;
	} item_t;

	typedef struct packed {
		logic [31:0] well_depth;
		logic [31:0] zero_distance;
		logic [31:0] cutoff_radius;
		logic [47:0] cell_volume;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic [2:0][63:0] fvec;
		logic [63:0]      energy;
		logic [5:0][63:0] stress;
		logic             last;
	} res_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? SMIN : SMAX;
		return s;
	endfunction

	function automatic logic [63:0] to_signed(input logic ovf, input logic [63:0] mag,
		input logic neg);
		logic [63:0] lim;
		logic [63:0] m;
		lim = neg ? SMIN : SMAX;
		m = (ovf || mag > lim) ? lim : mag;
		return neg ? (64'd0 - m) : m;
	endfunction

	// virial pairs xx yy zz xy xz yz
	function automatic logic [1:0] vir_a(input logic [2:0] k);
		case (k)
			3'd0: return 2'd0;
			3'd1: return 2'd1;
			3'd2: return 2'd2;
			3'd3: return 2'd0;
			3'd4: return 2'd0;
			3'd5: return 2'd1;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] vir_b(input logic [2:0] k);
		case (k)
			3'd0: return 2'd0;
			3'd1: return 2'd1;
			3'd2: return 2'd2;
			3'd3: return 2'd1;
			3'd4: return 2'd2;
			3'd5: return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

endpackage

@@ rtl/core/ljpf_front.sv @@
// front end: accepts items, splits displacements into magnitude and sign, queues them
// depends on ljpf_pkg
module ljpf_front #(
	parameter int unsigned QUEUE_DEPTH = ljpf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               pair_valid,
	input  logic signed [31:0] disp_x,
	input  logic signed [31:0] disp_y,
	input  logic signed [31:0] disp_z,
	input  logic               atom_end,
	input  logic               frame_end,
	output logic               q_valid,
	output ljpf_pkg::item_t    q_item,
	input  logic               q_pop
);
	import ljpf_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	item_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	item_t          new_item;
	logic           push;

	always_comb begin
		new_item.pair_valid = pair_valid;
		new_item.dn = {disp_z[31], disp_y[31], disp_x[31]};
		new_item.d[0] = disp_x[31] ? 32'(-disp_x) : 32'(disp_x);
		new_item.d[1] = disp_y[31] ? 32'(-disp_y) : 32'(disp_y);
		new_item.d[2] = disp_z[31] ? 32'(-disp_z) : 32'(disp_z);
		new_item.atom_end = atom_end;
		new_item.frame_end = frame_end;
	end

	assign in_ready = (cnt_q != CW'(QUEUE_DEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop && q_valid)
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !(q_pop && q_valid))
				cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop && q_valid)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= new_item;
	end

endmodule

@@ rtl/core/ljpf_mul.sv @@
// iterative 64x64 unsigned multiplier, one 32x32 partial product a cycle
// no dependencies
module ljpf_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);
	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q, ppv_s1;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q, pp_shift;
	logic [31:0]  a_half, b_half;

	always_comb begin
		a_half = cnt_q[0] ? a_q[63:32] : a_q[31:0];
		b_half = cnt_q[1] ? b_q[63:32] : b_q[31:0];
		case (sh_s1)
			2'd0: pp_shift = {64'd0, pp_s1};
			2'd1: pp_shift = {32'd0, pp_s1, 32'd0};
			2'd2: pp_shift = {pp_s1, 64'd0};
			default: pp_shift = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ppv_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				busy_q <= 1'b1;
				ppv_s1 <= 1'b0;
			end else if (busy_q) begin
				if (cnt_q != 3'd4) begin
					cnt_q <= cnt_q + 1'b1;
					ppv_s1 <= 1'b1;
				end else begin
					ppv_s1 <= 1'b0;
					if (ppv_s1) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_s1 <= a_half * b_half;
				sh_s1 <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
			end
			if (ppv_s1)
				acc_q <= acc_q + pp_shift;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ rtl/core/ljpf_div.sv @@
// restoring 128 by 64 divider, one quotient bit a cycle, saturating at all ones
// no dependencies
module ljpf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] hi,
	input  logic [63:0] lo,
	input  logic [63:0] d,
	output logic        done,
	output logic [63:0] quo
);
	logic [63:0] r_q, lo_q, d_q, quo_q, rs;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q, take;

	always_comb begin
		rs = {r_q[62:0], lo_q[63]};
		take = r_q[63] || (rs >= d_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (hi >= d) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= 6'd63;
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= hi;
			lo_q <= lo;
			d_q <= d;
			quo_q <= (hi >= d) ? 64'hffff_ffff_ffff_ffff : 64'd0;
		end else if (busy_q) begin
			r_q <= take ? (rs - d_q) : rs;
			quo_q <= {quo_q[62:0], take};
			lo_q <= {lo_q[62:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

@@ rtl/core/ljpf_back.sv @@
// back end sequencer: pair force, energy and virial sums, atom and frame results
// depends on ljpf_pkg, ljpf_mul, ljpf_div
module ljpf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ljpf_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  ljpf_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output ljpf_pkg::res_t  res
);
	import ljpf_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_R2, S_RC2, S_S2, S_CHK, S_DQ, S_QQ, S_Q3, S_Q6, S_EN, S_TC,
		S_ET, S_DC, S_F, S_V, S_END, S_AOUT, S_SD, S_FOUT
	} state_t;

	state_t          state_q;
	item_t           it_q;
	logic            issued_q;
	logic [2:0]      idx_q;
	logic [63:0]     r2_q, rc2_q, s2_q, q_q, p_q, q3_q, q6_q, t_q, c_q;
	logic            tneg_q;
	logic [127:0]    etp_q;
	logic [2:0][63:0] f_q, asum_q;
	logic [63:0]     esum_q;
	logic [5:0][63:0] vsum_q, st_q;
	logic            out_valid_q;
	res_t            res_q;

	logic            is_mul, is_div, mul_start, div_start, mul_done, div_done, out_free;
	logic [63:0]     ma, mb, dhi, dlo, dd, quo, fmag, vmag, fval;
	logic [127:0]    prod;
	logic [1:0]      va, vb;
	logic [67:0]     t12, t6, tdiff;
	logic            vol_zero;
	logic [63:0]     psat;

	assign vol_zero = (cfg.cell_volume == '0);
	assign out_free = !out_valid_q || out_ready;
	assign va = vir_a(idx_q);
	assign vb = vir_b(idx_q);

	always_comb begin
		is_mul = (state_q == S_R2) || (state_q == S_RC2) || (state_q == S_S2) ||
			(state_q == S_QQ) || (state_q == S_Q3) || (state_q == S_Q6) ||
			(state_q == S_EN) || (state_q == S_ET) || (state_q == S_F) || (state_q == S_V);
		is_div = (state_q == S_DQ) || (state_q == S_DC) || (state_q == S_SD && !vol_zero);
		mul_start = is_mul && !issued_q;
		div_start = is_div && !issued_q;
		fmag = f_q[vb][63] ? (64'd0 - f_q[vb]) : f_q[vb];
		vmag = vsum_q[idx_q][63] ? (64'd0 - vsum_q[idx_q]) : vsum_q[idx_q];
		psat = (prod[127:96] != '0) ? UMAX : prod[95:32];
		fval = to_signed(prod[127:80] != '0, prod[79:16], tneg_q ^ it_q.dn[idx_q[1:0]]);
		t12 = {1'b0, q6_q, 3'd0} + {2'b0, q6_q, 2'd0};
		t6 = {2'b0, q3_q, 2'd0} + {3'b0, q3_q, 1'b0};
		tdiff = (t12 < t6) ? (t6 - t12) : (t12 - t6);
		ma = '0;
		mb = '0;
		case (state_q)
			S_R2: begin
				ma = {32'd0, it_q.d[idx_q[1:0]]};
				mb = {32'd0, it_q.d[idx_q[1:0]]};
			end
			S_RC2: begin
				ma = {32'd0, cfg.cutoff_radius};
				mb = {32'd0, cfg.cutoff_radius};
			end
			S_S2: begin
				ma = {32'd0, cfg.zero_distance};
				mb = {32'd0, cfg.zero_distance};
			end
			S_QQ: begin
				ma = q_q;
				mb = q_q;
			end
			S_Q3: begin
				ma = p_q;
				mb = q_q;
			end
			S_Q6: begin
				ma = q3_q;
				mb = q3_q;
			end
			S_EN: begin
				ma = {32'd0, cfg.well_depth};
				mb = (q6_q >= q3_q) ? (q6_q - q3_q) : (q3_q - q6_q);
			end
			S_ET: begin
				ma = {32'd0, cfg.well_depth};
				mb = t_q;
			end
			S_F: begin
				ma = c_q;
				mb = {32'd0, it_q.d[idx_q[1:0]]};
			end
			S_V: begin
				ma = {32'd0, it_q.d[va]};
				mb = fmag;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		case (state_q)
			S_DQ: begin
				dhi = {32'd0, s2_q[63:32]};
				dlo = {s2_q[31:0], 32'd0};
				dd = r2_q;
			end
			S_DC: begin
				dhi = etp_q[127:64];
				dlo = etp_q[63:0];
				dd = r2_q;
			end
			default: begin
				dhi = {49'd0, vmag[63:49]};
				dlo = {vmag[48:0], 15'd0};
				dd = {16'd0, cfg.cell_volume};
			end
		endcase
	end

	ljpf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(ma), .b(mb),
		.done(mul_done), .prod(prod)
	);

	ljpf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .hi(dhi), .lo(dlo), .d(dd),
		.done(div_done), .quo(quo)
	);

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			asum_q <= '0;
			esum_q <= '0;
			vsum_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_AOUT && state_q != S_FOUT)
				out_valid_q <= 1'b0;
			if ((mul_done && is_mul) || (div_done && is_div))
				issued_q <= 1'b0;
			else if (mul_start || div_start)
				issued_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q <= q_item;
						idx_q <= '0;
						r2_q <= '0;
						state_q <= q_item.pair_valid ? S_R2 : S_END;
					end
				end
				S_R2: begin
					if (mul_done) begin
						r2_q <= r2_q + prod[63:0];
						if (idx_q == 3'd2) begin
							idx_q <= '0;
							state_q <= S_RC2;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_RC2: begin
					if (mul_done) begin
						rc2_q <= prod[63:0];
						state_q <= S_S2;
					end
				end
				S_S2: begin
					if (mul_done) begin
						s2_q <= prod[63:0];
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= (r2_q == '0 || r2_q > rc2_q) ? S_END : S_DQ;
				end
				S_DQ: begin
					if (div_done) begin
						q_q <= quo;
						state_q <= S_QQ;
					end
				end
				S_QQ: begin
					if (mul_done) begin
						p_q <= psat;
						state_q <= S_Q3;
					end
				end
				S_Q3: begin
					if (mul_done) begin
						q3_q <= psat;
						state_q <= S_Q6;
					end
				end
				S_Q6: begin
					if (mul_done) begin
						q6_q <= psat;
						state_q <= S_EN;
					end
				end
				S_EN: begin
					if (mul_done) begin
						esum_q <= sat_add(esum_q,
							to_signed(prod[127:78] != '0, prod[77:14], q6_q < q3_q));
						state_q <= S_TC;
					end
				end
				S_TC: begin
					tneg_q <= (t12 < t6);
					t_q <= (tdiff[67:64] != '0) ? UMAX : tdiff[63:0];
					state_q <= S_ET;
				end
				S_ET: begin
					if (mul_done) begin
						etp_q <= {prod[109:0], 18'd0};
						state_q <= S_DC;
					end
				end
				S_DC: begin
					if (div_done) begin
						c_q <= quo;
						idx_q <= '0;
						state_q <= S_F;
					end
				end
				S_F: begin
					if (mul_done) begin
						f_q[idx_q[1:0]] <= fval;
						asum_q[idx_q[1:0]] <= sat_add(asum_q[idx_q[1:0]], fval);
						if (idx_q == 3'd2) begin
							idx_q <= '0;
							state_q <= S_V;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_V: begin
					if (mul_done) begin
						vsum_q[idx_q] <= sat_add(vsum_q[idx_q],
							to_signed(prod[127:80] != '0, prod[79:16],
								it_q.dn[va] ^ f_q[vb][63]));
						if (idx_q == 3'd5) begin
							idx_q <= '0;
							state_q <= S_END;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_END: begin
					idx_q <= '0;
					if (it_q.atom_end)
						state_q <= S_AOUT;
					else if (it_q.frame_end)
						state_q <= S_SD;
					else
						state_q <= S_IDLE;
				end
				S_AOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q.kind <= RES_ATOM;
						res_q.fvec <= asum_q;
						res_q.energy <= '0;
						res_q.stress <= '0;
						res_q.last <= !it_q.frame_end;
						asum_q <= '0;
						state_q <= it_q.frame_end ? S_SD : S_IDLE;
					end else begin
						out_valid_q <= out_valid_q;
					end
				end
				S_SD: begin
					if (vol_zero || div_done) begin
						st_q[idx_q] <= vol_zero ? 64'd0 : to_signed(1'b0, quo, vsum_q[idx_q][63]);
						if (idx_q == 3'd5) begin
							idx_q <= '0;
							state_q <= S_FOUT;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_FOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q.kind <= RES_FRAME;
						res_q.fvec <= '0;
						res_q.energy <= {esum_q[63], esum_q[63:1]};
						res_q.stress <= st_q;
						res_q.last <= 1'b1;
						asum_q <= '0;
						esum_q <= '0;
						vsum_q <= '0;
						state_q <= S_IDLE;
					end else begin
						out_valid_q <= out_valid_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

endmodule

@@ rtl/core/lennard_jones_pair_force.sv @@
// top level of the lennard-jones 12-6 pair force, energy and virial block
// depends on ljpf_pkg, ljpf_front, ljpf_back; holds the configuration registers
// usage:
//   input channel in_valid/in_ready carries one neighbour pair item (or a bare end mark)
//   output channel out_valid/out_ready carries atom force and frame energy/stress items
//   apb port writes well_depth, zero_distance, cutoff_radius, cell_volume at 0, 8, 16, 24
//   a small queue decouples acceptance from the arithmetic engine
// timing:
//   items are worked one at a time by a shared multiplier and a one-bit-a-cycle
//   divider; a pair inside the cutoff takes two divisions and nineteen
//   multiplications, a pair outside it ends at the cutoff check
//   a frame end adds six stress divisions unless the cell volume is zero
//   results are registered by the atom and frame output states once the output register is free
// reset:
//   all sums clear, registers take their defaults, queue and output empty
// stalls:
//   a waiting result holds in the output register; the engine works on and waits for it to
//   drain only when its next result is due, while the queue keeps taking items until full
module lennard_jones_pair_force #(
	parameter int unsigned QUEUE_DEPTH = ljpf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ljpf_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        pair_valid,
	input  logic signed [31:0]          disp_x,
	input  logic signed [31:0]          disp_y,
	input  logic signed [31:0]          disp_z,
	input  logic                        atom_end,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        result_kind,
	output logic signed [63:0]          force_x,
	output logic signed [63:0]          force_y,
	output logic signed [63:0]          force_z,
	output logic signed [63:0]          total_energy,
	output logic signed [63:0]          stress_xx,
	output logic signed [63:0]          stress_yy,
	output logic signed [63:0]          stress_zz,
	output logic signed [63:0]          stress_xy,
	output logic signed [63:0]          stress_xz,
	output logic signed [63:0]          stress_yz,
	output logic                        run_last
);
	import ljpf_pkg::*;

	cfg_t       cfg_q;
	logic       q_valid, q_pop;
	item_t      q_item;
	res_t       res;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.well_depth <= 32'd65536;
			cfg_q.zero_distance <= 32'd65536;
			cfg_q.cutoff_radius <= 32'd655360;
			cfg_q.cell_volume <= 48'd65536000;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_WELL:   cfg_q.well_depth <= pwdata[31:0];
				REG_SIGMA:  cfg_q.zero_distance <= pwdata[31:0];
				REG_CUTOFF: cfg_q.cutoff_radius <= pwdata[31:0];
				REG_VOLUME: cfg_q.cell_volume <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WELL:   prdata = {32'd0, cfg_q.well_depth};
			REG_SIGMA:  prdata = {32'd0, cfg_q.zero_distance};
			REG_CUTOFF: prdata = {32'd0, cfg_q.cutoff_radius};
			REG_VOLUME: prdata = {16'd0, cfg_q.cell_volume};
			default:    prdata = '0;
		endcase
	end

	ljpf_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.pair_valid(pair_valid), .disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z),
		.atom_end(atom_end), .frame_end(frame_end),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	ljpf_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign result_kind = res.kind;
	assign force_x = res.fvec[0];
	assign force_y = res.fvec[1];
	assign force_z = res.fvec[2];
	assign total_energy = res.energy;
	assign stress_xx = res.stress[0];
	assign stress_yy = res.stress[1];
	assign stress_zz = res.stress[2];
	assign stress_xy = res.stress[3];
	assign stress_xz = res.stress[4];
	assign stress_yz = res.stress[5];
	assign run_last = res.last;

	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_FRAME |-> run_last)
		else $error("frame item without last flag");

	a_atom_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_ATOM |-> total_energy == 0 && stress_xx == 0)
		else $error("atom item carries frame values");

	a_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_FRAME |-> force_x == 0 && force_z == 0)
		else $error("frame item carries force values");

endmodule

@@ test/tb.sv @@
// self-checking testbench for lennard_jones_pair_force: directed and random pair items,
// a fixed-point predictor in a small scoreboard class, apb register phases
// depends on ljpf_pkg and the lennard_jones_pair_force rtl
`timescale 1ns / 1ps

import ljpf_pkg::*;

class lj_tally;
	logic [31:0] eps, sig, rcut;
	logic [47:0] vol;
	logic [63:0] fsum [3];
	logic [63:0] esum;
	logic [63:0] vsum [6];
	res_t owed_results [$];
	int errors;

	function new();
		eps = 32'd65536;
		sig = 32'd65536;
		rcut = 32'd655360;
		vol = 48'd65536000;
		foreach (fsum[i]) fsum[i] = '0;
		foreach (vsum[i]) vsum[i] = '0;
		esum = '0;
		errors = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [63:0] val);
		case (idx)
			REG_WELL:   eps = val[31:0];
			REG_SIGMA:  sig = val[31:0];
			REG_CUTOFF: rcut = val[31:0];
			REG_VOLUME: vol = val[47:0];
			default: ;
		endcase
	endfunction

	function logic [63:0] clamp(logic ovf, logic [63:0] mag, logic neg);
		logic [63:0] lim, m;
		lim = neg ? SMIN : SMAX;
		m = (ovf || mag > lim) ? lim : mag;
		return neg ? 64'd0 - m : m;
	endfunction

	function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? SMIN : SMAX;
		return s;
	endfunction

	function logic [63:0] quot_sat(logic [127:0] num, logic [63:0] den);
		logic [127:0] qq;
		qq = num / {64'd0, den};
		return (qq[127:64] != 0) ? UMAX : qq[63:0];
	endfunction

	function logic [63:0] prod_u(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		return (p[127:64] != 0) ? UMAX : p[63:0];
	endfunction

	function logic [63:0] prod_s(logic [63:0] a, logic [63:0] b, int sh, logic neg);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		return clamp(p[127:64] != 0, p[63:0], neg);
	endfunction

	function void accumulate_pair(logic [63:0] d [3], logic dn [3]);
		logic [63:0] r2, rc2, s2, q, q3, q6, t, c, fm;
		logic [127:0] a12, b6, diff, num;
		logic [63:0] f [3];
		logic tneg;
		int va [6], vb [6];
		va = '{0, 1, 2, 0, 0, 1};
		vb = '{0, 1, 2, 1, 2, 2};
		r2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
		rc2 = {32'd0, rcut} * {32'd0, rcut};
		if (r2 == 0 || r2 > rc2)
			return;
		s2 = {32'd0, sig} * {32'd0, sig};
		q = quot_sat({64'd0, s2} << 32, r2);
		q3 = prod_u(prod_u(q, q, 32), q, 32);
		q6 = prod_u(q3, q3, 32);
		if (q6 >= q3)
			esum = add_sat(esum, prod_s({32'd0, eps}, q6 - q3, 14, 1'b0));
		else
			esum = add_sat(esum, prod_s({32'd0, eps}, q3 - q6, 14, 1'b1));
		a12 = {64'd0, q6} * 128'd12;
		b6 = {64'd0, q3} * 128'd6;
		tneg = a12 < b6;
		diff = tneg ? b6 - a12 : a12 - b6;
		t = (diff[127:64] != 0) ? UMAX : diff[63:0];
		num = ({96'd0, eps} * {64'd0, t}) << 18;
		c = quot_sat(num, r2);
		for (int i = 0; i < 3; i++) begin
			f[i] = prod_s(c, d[i], 16, tneg != dn[i]);
			fsum[i] = add_sat(fsum[i], f[i]);
		end
		for (int k = 0; k < 6; k++) begin
			fm = f[vb[k]][63] ? 64'd0 - f[vb[k]] : f[vb[k]];
			vsum[k] = add_sat(vsum[k], prod_s(d[va[k]], fm, 16, dn[va[k]] != f[vb[k]][63]));
		end
	endfunction

	function void note_item(logic pv, logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic ae, logic fe);
		logic [63:0] d [3];
		logic dn [3];
		logic [31:0] raw [3];
		logic [63:0] m;
		res_t r;
		int n;
		raw = '{x, y, z};
		n = 0;
		if (pv) begin
			for (int i = 0; i < 3; i++) begin
				dn[i] = raw[i][31];
				d[i] = dn[i] ? 64'h1_0000_0000 - {32'd0, raw[i]} : {32'd0, raw[i]};
			end
			accumulate_pair(d, dn);
		end
		if (ae) begin
			r = '0;
			r.kind = RES_ATOM;
			for (int i = 0; i < 3; i++) begin
				r.fvec[i] = fsum[i];
				fsum[i] = '0;
			end
			r.last = !fe;
			owed_results.push_back(r);
		end
		if (fe) begin
			r = '0;
			r.kind = RES_FRAME;
			r.energy = {esum[63], esum[63:1]};
			for (int k = 0; k < 6; k++) begin
				if (vol != 0) begin
					m = vsum[k][63] ? 64'd0 - vsum[k] : vsum[k];
					r.stress[k] = clamp(1'b0, quot_sat({64'd0, m} << 15, {16'd0, vol}),
						vsum[k][63]);
				end
				vsum[k] = '0;
			end
			foreach (fsum[i]) fsum[i] = '0;
			esum = '0;
			r.last = 1'b1;
			owed_results.push_back(r);
		end
	endfunction

	function void cmp(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$error("%s expected %h actual %h", name, e, a);
			errors++;
		end
	endfunction

	function void check_result(res_t got);
		res_t e;
		if (owed_results.size() == 0) begin
			$error("result with nothing expected");
			errors++;
			return;
		end
		e = owed_results.pop_front();
		cmp("result_kind", e.kind, got.kind);
		cmp("force_x", e.fvec[0], got.fvec[0]);
		cmp("force_y", e.fvec[1], got.fvec[1]);
		cmp("force_z", e.fvec[2], got.fvec[2]);
		cmp("total_energy", e.energy, got.energy);
		cmp("stress_xx", e.stress[0], got.stress[0]);
		cmp("stress_yy", e.stress[1], got.stress[1]);
		cmp("stress_zz", e.stress[2], got.stress[2]);
		cmp("stress_xy", e.stress[3], got.stress[3]);
		cmp("stress_xz", e.stress[4], got.stress[4]);
		cmp("stress_yz", e.stress[5], got.stress[5]);
		cmp("run_last", e.last, got.last);
	endfunction
endclass

module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic pair_valid = 1'b0, atom_end = 1'b0, frame_end = 1'b0;
	logic signed [31:0] disp_x = '0, disp_y = '0, disp_z = '0;
	logic out_valid, out_ready = 1'b0;
	logic result_kind, run_last;
	logic signed [63:0] force_x, force_y, force_z, total_energy;
	logic signed [63:0] stress_xx, stress_yy, stress_zz, stress_xy, stress_xz, stress_yz;

	lj_tally tally = new();
	int sent = 0;
	int unsigned cycles = 0;
	res_t got;

	lennard_jones_pair_force DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) cycles <= cycles + 1;

	always @(negedge clk)
		out_ready <= (cycles > 30000 && cycles < 90000) || ($urandom_range(0, 99) >= 6);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got.kind = result_kind;
			got.fvec = {force_z, force_y, force_x};
			got.energy = total_energy;
			got.stress = {stress_yz, stress_xz, stress_xy, stress_zz, stress_yy, stress_xx};
			got.last = run_last;
			tally.check_result(got);
		end
	end

	task automatic send(logic pv, logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic ae, logic fe);
		if (!(sent > 500 && sent < 800) && $urandom_range(0, 99) < 6) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pair_valid = pv;
		disp_x = x;
		disp_y = y;
		disp_z = z;
		atom_end = ae;
		frame_end = fe;
		do @(posedge clk); while (!in_ready);
		tally.note_item(pv, x, y, z, ae, fe);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_W'(idx) << 3;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		tally.set_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (tally.owed_results.size() != 0)
			@(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_disp();
		int unsigned roll;
		logic [31:0] m;
		roll = $urandom_range(0, 99);
		if (roll < 72) begin
			m = $urandom_range(20000, 500000);
			return $urandom_range(0, 1) ? -m : m;
		end
		if (roll < 92)
			return $urandom;
		return '0;
	endfunction

	task automatic random_frames(int count);
		int stop, atoms, pairs;
		stop = sent + count;
		while (sent < stop) begin
			atoms = $urandom_range(1, 4);
			for (int a = 0; a < atoms; a++) begin
				pairs = $urandom_range(1, 6);
				for (int p = 0; p < pairs; p++) begin
					if ($urandom_range(0, 99) < 5)
						send(1'b0, $urandom, $urandom, $urandom, 1'b0, 1'b0);
					if ($urandom_range(0, 99) < 3)
						send(1'b1, pick_disp(), pick_disp(), pick_disp(), 1'b0, 1'b1);
					send(1'b1, pick_disp(), pick_disp(), pick_disp(),
						p == pairs - 1, p == pairs - 1 && a == atoms - 1);
				end
			end
			if ($urandom_range(0, 99) < 8)
				send(1'b0, $urandom, $urandom, $urandom, $urandom_range(0, 1),
					$urandom_range(0, 1));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(1'b1, 32'd65536, 32'd0, 32'd0, 1'b1, 1'b0);
		send(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0);
		send(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
		send(1'b1, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
		send(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
		send(1'b1, 32'd72000, -32'sd30000, 32'd10000, 1'b0, 1'b0);
		send(1'b1, -32'sd50000, 32'd60000, -32'sd70000, 1'b1, 1'b1);
		send(1'b1, 32'd40000, 32'd0, 32'd0, 1'b0, 1'b1);
		send(1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
		send(1'b1, 32'd655360, 32'd0, 32'd0, 1'b1, 1'b1);
		send(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
		send(1'b1, 32'd100000, 32'd80000, -32'sd90000, 1'b0, 1'b0);
		send(1'b0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1);
		random_frames(430);
		drain();

		write_reg(REG_WELL, 64'hffff_ffff);
		write_reg(REG_SIGMA, 64'hffff_ffff);
		write_reg(REG_CUTOFF, 64'hffff_ffff);
		write_reg(REG_VOLUME, 64'd1);
		random_frames(300);
		drain();

		write_reg(REG_WELL, 64'd0);
		write_reg(REG_SIGMA, 64'd0);
		write_reg(REG_CUTOFF, 64'd0);
		write_reg(REG_VOLUME, 64'd0);
		random_frames(150);
		drain();

		write_reg(REG_WELL, 64'($urandom));
		write_reg(REG_SIGMA, 64'd98304);
		write_reg(REG_CUTOFF, 64'd524288);
		write_reg(REG_VOLUME, 64'hffff_ffff_ffff);
		random_frames(400);
		drain();

		write_reg(REG_WELL, 64'd16384);
		write_reg(REG_SIGMA, 64'd65536);
		write_reg(REG_CUTOFF, 64'd655360);
		write_reg(REG_VOLUME, {16'd0, 16'($urandom), 32'($urandom)});
		random_frames(400);
		drain();

		if (tally.errors == 0)
			$display("lennard_jones_pair_force test passed");
		else
			$display("lennard_jones_pair_force test failed");
		$finish;
	end

	initial begin
		#48_000_000;
		$display("lennard_jones_pair_force test failed");
		$finish;
	end
endmodule
